/* sv/pdsd_pkg.sv */
// ----------------------------------------------------------------------------
// pdsd_pkg
// Types and constants for the pulse-distance sensor frame decoder: status
// codes, register indexes, register reset values and frame layout.
// ----------------------------------------------------------------------------
package pdsd_pkg;

    // Per-edge status reported with every transaction
    typedef enum logic [3:0] {
        ST_WAIT     = 4'd0,
        ST_START    = 4'd1,
        ST_FALLING  = 4'd2,
        ST_NEXT     = 4'd3,
        ST_OK       = 4'd4,
        ST_BAD_HIGH = 4'd5,
        ST_BAD_LOW  = 4'd6,
        ST_BAD_FLAG = 4'd7,
        ST_BAD_TEMP = 4'd8
    } status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SYNC_GAP_MIN   = 3'd0,
        REG_HIGH_PULSE_MIN = 3'd1,
        REG_HIGH_PULSE_MAX = 3'd2,
        REG_ZERO_GAP_MIN   = 3'd3,
        REG_ZERO_GAP_MAX   = 3'd4,
        REG_ONE_GAP_MIN    = 3'd5,
        REG_ONE_GAP_MAX    = 3'd6
    } reg_index_t;

    localparam int CFG_WIDTH   = 16;
    localparam int INDEX_WIDTH = 3;
    localparam int STAMP_WIDTH = 32;

    typedef logic [CFG_WIDTH-1:0] cfg_word_t;

    // Register reset values
    localparam cfg_word_t RST_SYNC_GAP_MIN   = 16'd3900;
    localparam cfg_word_t RST_HIGH_PULSE_MIN = 16'd400;
    localparam cfg_word_t RST_HIGH_PULSE_MAX = 16'd600;
    localparam cfg_word_t RST_ZERO_GAP_MIN   = 16'd900;
    localparam cfg_word_t RST_ZERO_GAP_MAX   = 16'd1100;
    localparam cfg_word_t RST_ONE_GAP_MIN    = 16'd1900;
    localparam cfg_word_t RST_ONE_GAP_MAX    = 16'd2100;

    // Frame layout
    localparam int FRAME_BITS = 36;
    localparam int COUNT_WIDTH = 6;
    localparam logic [COUNT_WIDTH-1:0] FRAME_COUNT = 6'd36;
    localparam logic [3:0] FLAG_NIBBLE = 4'hF;
    localparam logic signed [11:0] TEMP_MIN = -12'sd600;
    localparam logic signed [11:0] TEMP_MAX = 12'sd700;

    typedef logic [FRAME_BITS-1:0] frame_t;

endpackage

/* sv/pulse_distance_sensor_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// pulse_distance_sensor_frame_decoder_top
// Decodes 36-bit pulse-distance sensor frames from a stream of timed edges.
// ----------------------------------------------------------------------------
// Each accepted edge's status is registered into the output register.
// Throughput: one edge per cycle; the only limit is the single output register,
// which is refilled in the same cycle it is taken.
// Reset: idle, bit count and shift register cleared, previous time zero,
// registers at their default windows, output empty.
module pulse_distance_sensor_frame_decoder_top #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdsd_pkg::INDEX_WIDTH-1:0]     cfg_index,
    input  logic [pdsd_pkg::CFG_WIDTH-1:0]       cfg_data,
    // edge input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 rising,
    input  logic [pdsd_pkg::STAMP_WIDTH-1:0]     timestamp,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pdsd_pkg::status_t                    status,
    output logic [7:0]                           sensor_id,
    output logic                                 battery_low,
    output logic [1:0]                           channel,
    output logic signed [10:0]                   temperature,
    output logic [7:0]                           humidity
);
    import pdsd_pkg::*;

    localparam int TS_BITS = (TIME_WIDTH < STAMP_WIDTH) ? TIME_WIDTH : STAMP_WIDTH;

    typedef logic [TIME_WIDTH-1:0] time_word_t;

    // configuration registers
    cfg_word_t sync_gap_min_reg;
    cfg_word_t high_pulse_min_reg;
    cfg_word_t high_pulse_max_reg;
    cfg_word_t zero_gap_min_reg;
    cfg_word_t zero_gap_max_reg;
    cfg_word_t one_gap_min_reg;
    cfg_word_t one_gap_max_reg;

    // decoder state
    time_word_t               previous_time_reg, previous_time_next;
    logic                     frame_active_reg, frame_active_next;
    logic [COUNT_WIDTH-1:0]   bit_count_reg, bit_count_next;
    frame_t                   shift_bits_reg, shift_bits_next;

    // output register
    logic                     out_valid_reg;
    status_t                  status_reg, status_next;
    logic [7:0]               sensor_id_reg, sensor_id_next;
    logic                     battery_low_reg, battery_low_next;
    logic [1:0]               channel_reg, channel_next;
    logic signed [10:0]       temperature_reg, temperature_next;
    logic [7:0]               humidity_reg, humidity_next;

    logic                     in_accept;
    time_word_t               now;
    time_word_t               delta;
    logic                     high_ok;
    logic                     zero_ok;
    logic                     one_ok;
    logic                     sync_ok;
    logic                     bit_value;
    frame_t                   shifted;
    logic [COUNT_WIDTH-1:0]   count_inc;
    logic signed [11:0]       temp_raw;

    assign cfg_ready = 1'b1;

    // Output stage refills whenever it is empty or being drained
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // Edge interval, modulo the time width
    assign now   = TIME_WIDTH'(timestamp[TS_BITS-1:0]);
    assign delta = now - previous_time_reg;

    // Window checks; an inverted window matches nothing
    assign sync_ok = delta >= TIME_WIDTH'(sync_gap_min_reg);
    assign high_ok = (delta >= TIME_WIDTH'(high_pulse_min_reg))
                  && (delta <= TIME_WIDTH'(high_pulse_max_reg));
    assign zero_ok = (delta >= TIME_WIDTH'(zero_gap_min_reg))
                  && (delta <= TIME_WIDTH'(zero_gap_max_reg));
    assign one_ok  = (delta >= TIME_WIDTH'(one_gap_min_reg))
                  && (delta <= TIME_WIDTH'(one_gap_max_reg));

    // Zero window wins where the two bit windows overlap
    assign bit_value = !zero_ok;
    assign shifted   = {shift_bits_reg[FRAME_BITS-2:0], bit_value};
    assign count_inc = bit_count_reg + 1'b1;
    assign temp_raw  = $signed(shifted[23:12]);

    // Frame state machine and result decode
    always_comb
    begin
        previous_time_next = now;
        frame_active_next  = frame_active_reg;
        bit_count_next     = bit_count_reg;
        shift_bits_next    = shift_bits_reg;
        status_next        = ST_WAIT;
        sensor_id_next     = '0;
        battery_low_next   = 1'b0;
        channel_next       = '0;
        temperature_next   = '0;
        humidity_next      = '0;

        if (!frame_active_reg)
        begin
            if (rising && sync_ok)
            begin
                frame_active_next = 1'b1;
                bit_count_next    = '0;
                status_next       = ST_START;
            end
        end
        else if (!rising)
        begin
            if (high_ok)
            begin
                status_next = ST_FALLING;
            end
            else
            begin
                frame_active_next = 1'b0;
                bit_count_next    = '0;
                status_next       = ST_BAD_HIGH;
            end
        end
        else if (zero_ok || one_ok)
        begin
            shift_bits_next = shifted;
            if (count_inc != FRAME_COUNT)
            begin
                bit_count_next = count_inc;
                status_next    = ST_NEXT;
            end
            else
            begin
                // Full frame: check flag nibble, then temperature range
                frame_active_next = 1'b0;
                bit_count_next    = '0;
                if (shifted[11:8] != FLAG_NIBBLE)
                begin
                    status_next = ST_BAD_FLAG;
                end
                else if (temp_raw < TEMP_MIN || temp_raw > TEMP_MAX)
                begin
                    status_next = ST_BAD_TEMP;
                end
                else
                begin
                    status_next      = ST_OK;
                    sensor_id_next   = shifted[35:28];
                    battery_low_next = shifted[27];
                    channel_next     = shifted[25:24];
                    temperature_next = temp_raw[10:0];
                    humidity_next    = shifted[7:0];
                end
            end
        end
        else
        begin
            frame_active_next = 1'b0;
            bit_count_next    = '0;
            status_next       = ST_BAD_LOW;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_gap_min_reg   <= RST_SYNC_GAP_MIN;
            high_pulse_min_reg <= RST_HIGH_PULSE_MIN;
            high_pulse_max_reg <= RST_HIGH_PULSE_MAX;
            zero_gap_min_reg   <= RST_ZERO_GAP_MIN;
            zero_gap_max_reg   <= RST_ZERO_GAP_MAX;
            one_gap_min_reg    <= RST_ONE_GAP_MIN;
            one_gap_max_reg    <= RST_ONE_GAP_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_SYNC_GAP_MIN:   sync_gap_min_reg   <= cfg_data;
                REG_HIGH_PULSE_MIN: high_pulse_min_reg <= cfg_data;
                REG_HIGH_PULSE_MAX: high_pulse_max_reg <= cfg_data;
                REG_ZERO_GAP_MIN:   zero_gap_min_reg   <= cfg_data;
                REG_ZERO_GAP_MAX:   zero_gap_max_reg   <= cfg_data;
                REG_ONE_GAP_MIN:    one_gap_min_reg    <= cfg_data;
                REG_ONE_GAP_MAX:    one_gap_max_reg    <= cfg_data;
                default:            ; // unmapped index, write dropped
            endcase
        end
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_time_reg <= '0;
            frame_active_reg  <= 1'b0;
            bit_count_reg     <= '0;
            shift_bits_reg    <= '0;
        end
        else if (in_accept)
        begin
            previous_time_reg <= previous_time_next;
            frame_active_reg  <= frame_active_next;
            bit_count_reg     <= bit_count_next;
            shift_bits_reg    <= shift_bits_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg      <= status_next;
            sensor_id_reg   <= sensor_id_next;
            battery_low_reg <= battery_low_next;
            channel_reg     <= channel_next;
            temperature_reg <= temperature_next;
            humidity_reg    <= humidity_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign sensor_id   = sensor_id_reg;
    assign battery_low = battery_low_reg;
    assign channel     = channel_reg;
    assign temperature = temperature_reg;
    assign humidity    = humidity_reg;

endmodule
